// ===== sv/rmq_pkg.sv =====
`default_nettype none

package rmq_pkg;

   // Field and datapath widths.
   localparam int ELEM_W     = 16;
   localparam int RAW_W      = 18;
   localparam int MAG_W      = 17;
   localparam int SQ_W       = 34;
   localparam int SUM_W      = 36;
   localparam int ROOT_W     = 32;
   localparam int REM_W      = 34;
   localparam int SQRT_STEPS = 32;
   localparam int FRAC_SHIFT = 28;
   localparam int Q_W        = 17;
   localparam int NUM_W      = 47;
   localparam int DEN_W      = 33;
   localparam int DIV_STEPS  = 17;
   localparam int LANES      = 4;
   localparam int Q_ONE      = 16384;

   // Register count from the input capture to the result register.
   localparam int RSP_DELAY  = 4 + (SQRT_STEPS + 1) + (DIV_STEPS + 1) + 1;

   // Control that travels with each word.
   typedef struct packed {
      logic valid;
      logic ident;
   } ctrl_type;

   // Raw, unnormalised quaternion components in w, x, y, z order.
   typedef struct packed {
      logic [LANES-1:0][RAW_W-1:0] comp;
   } side_type;

endpackage

`default_nettype wire

// ===== sv/rmq_front.sv =====
`default_nettype none

module rmq_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  in_valid,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] m00,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] m01,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] m02,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] m10,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] m11,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] m12,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] m20,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] m21,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] m22,
   output rmq_pkg::ctrl_type                    ctrl_o,
   output rmq_pkg::side_type                    side_o,
   output logic [rmq_pkg::SUM_W-1:0]            sum_o
);

   localparam int RW = rmq_pkg::RAW_W;
   localparam logic signed [RW-1:0] ONE_RAW = RW'(rmq_pkg::Q_ONE);

   // Stage A: capture the matrix.
   rmq_pkg::ctrl_type a_ctrl_ff;
   logic signed [RW-1:0] a00_ff, a01_ff, a02_ff, a10_ff, a11_ff, a12_ff;
   logic signed [RW-1:0] a20_ff, a21_ff, a22_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff <= '0;
      end else begin
         a_ctrl_ff.valid <= in_valid;
         a_ctrl_ff.ident <= 1'b0;
      end
      a00_ff <= RW'(m00);
      a01_ff <= RW'(m01);
      a02_ff <= RW'(m02);
      a10_ff <= RW'(m10);
      a11_ff <= RW'(m11);
      a12_ff <= RW'(m12);
      a20_ff <= RW'(m20);
      a21_ff <= RW'(m21);
      a22_ff <= RW'(m22);
   end

   // Stage B: pick the pivot branch and form the raw vector.
   logic signed [RW-1:0] trace;
   logic signed [RW-1:0] pivot;
   logic [rmq_pkg::LANES-1:0][RW-1:0] comp_in;
   logic ident_in;

   always_comb begin
      trace = a00_ff + a11_ff + a22_ff;
      priority if (trace > 0) begin
         pivot = trace + ONE_RAW;
         comp_in[0] = pivot;
         comp_in[1] = a21_ff - a12_ff;
         comp_in[2] = a02_ff - a20_ff;
         comp_in[3] = a10_ff - a01_ff;
      end else if (a00_ff > a11_ff && a00_ff > a22_ff) begin
         pivot = ONE_RAW + a00_ff - a11_ff - a22_ff;
         comp_in[0] = a21_ff - a12_ff;
         comp_in[1] = pivot;
         comp_in[2] = a01_ff + a10_ff;
         comp_in[3] = a02_ff + a20_ff;
      end else if (a11_ff > a22_ff) begin
         pivot = ONE_RAW + a11_ff - a00_ff - a22_ff;
         comp_in[0] = a02_ff - a20_ff;
         comp_in[1] = a01_ff + a10_ff;
         comp_in[2] = pivot;
         comp_in[3] = a12_ff + a21_ff;
      end else begin
         pivot = ONE_RAW + a22_ff - a00_ff - a11_ff;
         comp_in[0] = a10_ff - a01_ff;
         comp_in[1] = a02_ff + a20_ff;
         comp_in[2] = a12_ff + a21_ff;
         comp_in[3] = pivot;
      end
      // A pivot that is not positive has no real root: give the identity.
      ident_in = (pivot <= 0);
   end

   rmq_pkg::ctrl_type b_ctrl_ff;
   rmq_pkg::side_type b_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctrl_ff <= '0;
      end else begin
         b_ctrl_ff.valid <= a_ctrl_ff.valid;
         b_ctrl_ff.ident <= ident_in;
      end
      b_side_ff.comp <= comp_in;
   end

   // Stage C: square the component magnitudes.
   logic [rmq_pkg::LANES-1:0][rmq_pkg::SQ_W-1:0] sq_in;
   logic [RW-1:0] abs_val;
   logic [rmq_pkg::MAG_W-1:0] mag;

   always_comb begin
      abs_val = '0;
      mag = '0;
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
         abs_val = b_side_ff.comp[i][RW-1] ? (~b_side_ff.comp[i] + 1'b1) : b_side_ff.comp[i];
         mag = abs_val[rmq_pkg::MAG_W-1:0];
         sq_in[i] = rmq_pkg::SQ_W'(mag) * rmq_pkg::SQ_W'(mag);
      end
   end

   rmq_pkg::ctrl_type c_ctrl_ff;
   rmq_pkg::side_type c_side_ff;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::SQ_W-1:0] c_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctrl_ff <= '0;
      end else begin
         c_ctrl_ff <= b_ctrl_ff;
      end
      c_side_ff <= b_side_ff;
      c_sq_ff   <= sq_in;
   end

   // Stage D: sum of squares.
   logic [rmq_pkg::SUM_W-1:0] sum_in;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
         sum_in = sum_in + rmq_pkg::SUM_W'(c_sq_ff[i]);
      end
   end

   rmq_pkg::ctrl_type d_ctrl_ff;
   rmq_pkg::side_type d_side_ff;
   logic [rmq_pkg::SUM_W-1:0] d_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ctrl_ff <= '0;
      end else begin
         d_ctrl_ff <= c_ctrl_ff;
      end
      d_side_ff <= c_side_ff;
      d_sum_ff  <= sum_in;
   end

   assign ctrl_o = d_ctrl_ff;
   assign side_o = d_side_ff;
   assign sum_o  = d_sum_ff;

endmodule

`default_nettype wire

// ===== sv/rmq_sqrt.sv =====
`default_nettype none

module rmq_sqrt (
   input  wire                              clock,
   input  wire                              reset,
   input  wire rmq_pkg::ctrl_type           ctrl_i,
   input  wire rmq_pkg::side_type           side_i,
   input  wire logic [rmq_pkg::SUM_W-1:0]   sum_i,
   output rmq_pkg::ctrl_type                ctrl_o,
   output rmq_pkg::side_type                side_o,
   output logic [rmq_pkg::ROOT_W-1:0]       root_o
);

   localparam int STEPS = rmq_pkg::SQRT_STEPS;
   localparam int SH_W  = rmq_pkg::REM_W + 2;

   rmq_pkg::ctrl_type ctrl_ff [0:STEPS];
   rmq_pkg::side_type side_ff [0:STEPS];
   logic [rmq_pkg::SUM_W-1:0]  sum_ff  [0:STEPS];
   logic [rmq_pkg::ROOT_W-1:0] root_ff [0:STEPS];
   logic [rmq_pkg::REM_W-1:0]  rem_ff  [0:STEPS];

   // Load stage: clear the root and remainder.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff[0] <= '0;
      end else begin
         ctrl_ff[0] <= ctrl_i;
      end
      side_ff[0] <= side_i;
      sum_ff[0]  <= sum_i;
      root_ff[0] <= '0;
      rem_ff[0]  <= '0;
   end

   // One root bit per stage; the radicand is the sum shifted up by 28 bits.
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int BIT = STEPS - 1 - k;
      localparam int LO  = 2 * BIT - rmq_pkg::FRAC_SHIFT;

      logic [1:0]                 pair;
      logic [SH_W-1:0]            rem_sh;
      logic [SH_W-1:0]            trial;
      logic [SH_W-1:0]            diff;
      logic                       take;
      logic [rmq_pkg::REM_W-1:0]  rem_in;
      logic [rmq_pkg::ROOT_W-1:0] root_in;

      if (LO >= 0) begin : g_pair
         assign pair = sum_ff[k][LO+1:LO];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      always_comb begin
         rem_sh  = {rem_ff[k], pair};
         trial   = SH_W'({root_ff[k], 2'b01});
         take    = (rem_sh >= trial);
         diff    = rem_sh - trial;
         rem_in  = take ? diff[rmq_pkg::REM_W-1:0] : rem_sh[rmq_pkg::REM_W-1:0];
         root_in = {root_ff[k][rmq_pkg::ROOT_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff[k+1] <= '0;
         end else begin
            ctrl_ff[k+1] <= ctrl_ff[k];
         end
         side_ff[k+1] <= side_ff[k];
         sum_ff[k+1]  <= sum_ff[k];
         root_ff[k+1] <= root_in;
         rem_ff[k+1]  <= rem_in;
      end
   end

   assign ctrl_o = ctrl_ff[STEPS];
   assign side_o = side_ff[STEPS];
   assign root_o = root_ff[STEPS];

endmodule

`default_nettype wire

// ===== sv/rmq_div.sv =====
`default_nettype none

module rmq_div (
   input  wire                                             clock,
   input  wire                                             reset,
   input  wire rmq_pkg::ctrl_type                          ctrl_i,
   input  wire rmq_pkg::side_type                          side_i,
   input  wire logic [rmq_pkg::ROOT_W-1:0]                 root_i,
   output rmq_pkg::ctrl_type                               ctrl_o,
   output logic [rmq_pkg::LANES-1:0][rmq_pkg::Q_W-1:0]     quot_o,
   output logic [rmq_pkg::LANES-1:0]                       neg_o
);

   localparam int STEPS = rmq_pkg::DIV_STEPS;
   localparam int LN    = rmq_pkg::LANES;
   localparam int RW    = rmq_pkg::RAW_W;
   localparam int NW    = rmq_pkg::NUM_W;
   localparam int CMP_W = rmq_pkg::DEN_W + STEPS - 1;
   localparam int SHIFT = NW - 1 - rmq_pkg::MAG_W;

   rmq_pkg::ctrl_type ctrl_ff [0:STEPS];
   logic [rmq_pkg::DEN_W-1:0]         den_ff  [0:STEPS];
   logic [LN-1:0][NW-1:0]             num_ff  [0:STEPS];
   logic [LN-1:0][rmq_pkg::Q_W-1:0]   quot_ff [0:STEPS];
   logic [LN-1:0]                     neg_ff  [0:STEPS];

   // Load stage: numerator is magnitude * 2^29 + root, divisor is 2 * root.
   logic [LN-1:0][NW-1:0] num_load;
   logic [LN-1:0]         neg_load;
   logic [RW-1:0]         abs_val;

   always_comb begin
      abs_val = '0;
      for (int i = 0; i < LN; i++) begin
         neg_load[i] = side_i.comp[i][RW-1];
         abs_val = neg_load[i] ? (~side_i.comp[i] + 1'b1) : side_i.comp[i];
         num_load[i] = {1'b0, abs_val[rmq_pkg::MAG_W-1:0], SHIFT'(0)} + NW'(root_i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff[0] <= '0;
      end else begin
         ctrl_ff[0] <= ctrl_i;
      end
      den_ff[0]  <= {root_i, 1'b0};
      num_ff[0]  <= num_load;
      quot_ff[0] <= '0;
      neg_ff[0]  <= neg_load;
   end

   // Restoring division, one quotient bit per stage, four lanes abreast.
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int BIT = STEPS - 1 - k;

      logic [CMP_W-1:0]                dsh;
      logic [CMP_W-1:0]                diff;
      logic [LN-1:0]                   take;
      logic [LN-1:0][NW-1:0]           num_in;
      logic [LN-1:0][rmq_pkg::Q_W-1:0] quot_in;

      always_comb begin
         dsh  = CMP_W'(den_ff[k]) << BIT;
         diff = '0;
         for (int i = 0; i < LN; i++) begin
            take[i]       = (CMP_W'(num_ff[k][i]) >= dsh);
            diff          = CMP_W'(num_ff[k][i]) - dsh;
            num_in[i]     = take[i] ? diff[NW-1:0] : num_ff[k][i];
            quot_in[i]    = quot_ff[k][i];
            quot_in[i][BIT] = take[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff[k+1] <= '0;
         end else begin
            ctrl_ff[k+1] <= ctrl_ff[k];
         end
         den_ff[k+1]  <= den_ff[k];
         num_ff[k+1]  <= num_in;
         quot_ff[k+1] <= quot_in;
         neg_ff[k+1]  <= neg_ff[k];
      end
   end

   assign ctrl_o = ctrl_ff[STEPS];
   assign quot_o = quot_ff[STEPS];
   assign neg_o  = neg_ff[STEPS];

endmodule

`default_nettype wire

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Each word reaches the result register through the front, root and divider stages.
// Throughput: one word per cycle while busy is low; four front stages, a 33-stage
// square root (one root bit per stage) and an 18-stage four-lane divider set the
// depth. busy is a registered copy of reset; the receiver cannot stall results.
// Reset is synchronous and clears every valid bit, so words in flight are dropped.
`default_nettype none

module rotation_matrix_to_quaternion (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] req_m00,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] req_m01,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] req_m02,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] req_m10,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] req_m11,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] req_m12,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] req_m20,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] req_m21,
   input  wire logic signed [rmq_pkg::ELEM_W-1:0] req_m22,
   output logic                                  rsp_valid,
   output logic signed [rmq_pkg::ELEM_W-1:0]     rsp_quat_w,
   output logic signed [rmq_pkg::ELEM_W-1:0]     rsp_quat_x,
   output logic signed [rmq_pkg::ELEM_W-1:0]     rsp_quat_y,
   output logic signed [rmq_pkg::ELEM_W-1:0]     rsp_quat_z
);

   localparam int EW = rmq_pkg::ELEM_W;
   localparam int QW = rmq_pkg::Q_W;
   localparam logic [QW-1:0] POS_MAX = QW'(32767);
   localparam logic [QW-1:0] NEG_MAX = QW'(32768);

   // Busy follows reset, so no word is taken while the pipe is cleared.
   logic busy_ff;
   logic accept;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // Raw vector and sum of squares.
   rmq_pkg::ctrl_type front_ctrl;
   rmq_pkg::side_type front_side;
   logic [rmq_pkg::SUM_W-1:0] front_sum;

   rmq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .m00      (req_m00),
      .m01      (req_m01),
      .m02      (req_m02),
      .m10      (req_m10),
      .m11      (req_m11),
      .m12      (req_m12),
      .m20      (req_m20),
      .m21      (req_m21),
      .m22      (req_m22),
      .ctrl_o   (front_ctrl),
      .side_o   (front_side),
      .sum_o    (front_sum)
   );

   // Norm with 14 extra fraction bits.
   rmq_pkg::ctrl_type sqrt_ctrl;
   rmq_pkg::side_type sqrt_side;
   logic [rmq_pkg::ROOT_W-1:0] sqrt_root;

   rmq_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .ctrl_i (front_ctrl),
      .side_i (front_side),
      .sum_i  (front_sum),
      .ctrl_o (sqrt_ctrl),
      .side_o (sqrt_side),
      .root_o (sqrt_root)
   );

   // Rounded quotients of each component over the norm.
   rmq_pkg::ctrl_type div_ctrl;
   logic [rmq_pkg::LANES-1:0][QW-1:0] div_quot;
   logic [rmq_pkg::LANES-1:0]         div_neg;

   rmq_div u_div (
      .clock  (clock),
      .reset  (reset),
      .ctrl_i (sqrt_ctrl),
      .side_i (sqrt_side),
      .root_i (sqrt_root),
      .ctrl_o (div_ctrl),
      .quot_o (div_quot),
      .neg_o  (div_neg)
   );

   // Saturate, apply the sign and substitute the identity where needed.
   logic [rmq_pkg::LANES-1:0][EW-1:0] quat_in;
   logic [QW-1:0] neg_q;

   always_comb begin
      neg_q = '0;
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
         neg_q = ~div_quot[i] + 1'b1;
         if (div_neg[i]) begin
            quat_in[i] = (div_quot[i] > NEG_MAX) ? NEG_MAX[EW-1:0] : neg_q[EW-1:0];
         end else begin
            quat_in[i] = (div_quot[i] > POS_MAX) ? POS_MAX[EW-1:0] : div_quot[i][EW-1:0];
         end
      end
      if (div_ctrl.ident) begin
         quat_in[0] = EW'(rmq_pkg::Q_ONE);
         quat_in[1] = '0;
         quat_in[2] = '0;
         quat_in[3] = '0;
      end
   end

   // Result register and strobe.
   logic rsp_valid_ff;
   logic [rmq_pkg::LANES-1:0][EW-1:0] quat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_ctrl.valid;
      end
      quat_ff <= quat_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_w = $signed(quat_ff[0]);
   assign rsp_quat_x = $signed(quat_ff[1]);
   assign rsp_quat_y = $signed(quat_ff[2]);
   assign rsp_quat_z = $signed(quat_ff[3]);

   // Every accepted word comes out after the fixed pipeline depth.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(rmq_pkg::RSP_DELAY) rsp_valid)
      else $error("accepted word did not emerge after the pipeline depth");

   // No result without a word accepted at the matching earlier edge.
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, rmq_pkg::RSP_DELAY))
      else $error("result strobe without a matching accepted word");

   // A unit quaternion keeps its scalar part within one.
   a_w_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_w <= 16384 && rsp_quat_w >= -16384))
      else $error("scalar part beyond unit magnitude");

endmodule

`default_nettype wire
